@@ src/cwf_pkg.sv @@
// Shared types, constants and helpers for the 3x3 window filter.
`timescale 1ns / 1ps

package cwf_pkg;

  localparam int CWF_MAX_WIDTH = 128;
  localparam int KSIZE         = 3;
  localparam int NTAPS         = KSIZE * KSIZE;
  localparam int PIX_BITS      = 8;
  localparam int FW_BITS       = 8;
  localparam int FH_BITS       = 12;
  localparam int COEF_BITS     = KSIZE * PIX_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int MIN_DIM       = 3;
  localparam int RESET_DIM     = 128;

  typedef logic [PIX_BITS-1:0] pixel_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_COEF_TOP,
    REG_COEF_MIDDLE,
    REG_COEF_BOTTOM
  } cwf_reg_t;

  // load strobes for the two MAC pipeline registers
  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } cwf_mac_ctl_t;

  // low byte of pixel * coefficient; same bits for signed or unsigned coef
  function automatic pixel_t prod_lo(input pixel_t px, input pixel_t cb);
    logic [2*PIX_BITS-1:0] p;
    p = px * cb;
    return p[PIX_BITS-1:0];
  endfunction

endpackage

@@ src/conv3x3_valid_window_filter.sv @@
// Top level: 3x3 valid-window convolution over a raster pixel stream.
`timescale 1ns / 1ps

// Takes one 8-bit pixel per clock, in raster order, while in_stall is low;
// once the 3x3 window lies inside the frame (row >= 2 and column >= 2), it
// emits one result per pixel: low byte of the sum of nine pixel*signed-coef
// products. frame_last marks the final result of a frame; counters then wrap
// to zero. Sustained rate, while out_stall is low, is one item per cycle with
// no gaps, end of row or frame included. An accepted pixel reaches its result
// through five registers: input register (loaded at the accepting edge),
// line-store read (registered), window update, product register, sum/output
// register. Each stage holds when the one after it is full and blocked, so
// inputs keep flowing while a result waits on out_stall until all five
// stages are full. Line stores are MAX_WIDTH deep memories with one valid
// flop per entry, so reset takes effect at once and needs no clearing pass.
// frame_width is clamped to 3..MAX_WIDTH and frame_height to at least 3.
// Write configuration only while idle; indexes past the register list are
// ignored. cfg_ready is always high.

module conv3x3_valid_window_filter import cwf_pkg::*; #(
  parameter int MAX_WIDTH = CWF_MAX_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pixel_t                  pixel_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output pixel_t                  pixel_out,
  output logic                    frame_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]    cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > FW_BITS) ? WW : FW_BITS;
  localparam logic [XW-1:0] MAXW = XW'(MAX_WIDTH);

  // configuration registers
  logic [FW_BITS-1:0]              frame_width;
  logic [FH_BITS-1:0]              frame_height;
  logic [KSIZE-1:0][COEF_BITS-1:0] coef;

  // position counters
  logic [CW-1:0]      column_position;
  logic [FH_BITS-1:0] row_position;

  // pipeline occupancy and per-item tags
  logic          v1, v2, v3, v4, vo;
  pixel_t        px1, px2;
  logic [CW-1:0] col1, col2;
  logic          prod1, prod2, prod3;
  logic          last1, last2, last3, last4;

  logic [NTAPS-1:0][PIX_BITS-1:0] window;

  logic [XW-1:0]      fw_x, ew;
  logic [FH_BITS-1:0] eh;
  logic               row_end, frame_end, produce;
  logic               accept;
  logic               o_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic               m1, m2, m3, m4;
  pixel_t             upper_rd, lower_rd;
  cwf_mac_ctl_t       mac_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_BITS'(RESET_DIM);
      frame_height <= FH_BITS'(RESET_DIM);
      coef         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_BITS-1:0];
        REG_COEF_TOP:     coef[0]      <= cfg_data;
        REG_COEF_MIDDLE:  coef[1]      <= cfg_data;
        REG_COEF_BOTTOM:  coef[2]      <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size and position decode for the incoming pixel
  always_comb begin
    fw_x = XW'(frame_width);
    if (fw_x < XW'(MIN_DIM)) begin
      ew = XW'(MIN_DIM);
    end else if (fw_x > MAXW) begin
      ew = MAXW;
    end else begin
      ew = fw_x;
    end
    eh = (frame_height < FH_BITS'(MIN_DIM)) ? FH_BITS'(MIN_DIM) : frame_height;
    row_end   = XW'(column_position) >= (ew - XW'(1));
    frame_end = row_end && (row_position >= (eh - FH_BITS'(1)));
    produce   = (row_position >= FH_BITS'(KSIZE - 1)) &&
                (column_position >= CW'(KSIZE - 1));
  end

  // stage handshake: a stage moves when the next one is empty or moving
  assign o_rdy  = !vo || !out_stall;
  assign s4_rdy = !v4 || o_rdy;
  assign s3_rdy = !v3 || s4_rdy;
  assign s2_rdy = !v2 || s3_rdy;
  assign s1_rdy = !v1 || s2_rdy;
  assign m1 = v1 && s2_rdy;
  assign m2 = v2 && s3_rdy;
  assign m3 = v3 && s4_rdy;
  assign m4 = v4 && o_rdy;

  assign in_stall = !s1_rdy;
  assign accept   = in_valid && s1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (accept) begin
        if (frame_end) begin
          column_position <= '0;
          row_position    <= '0;
        end else if (row_end) begin
          column_position <= '0;
          row_position    <= row_position + FH_BITS'(1);
        end else begin
          column_position <= column_position + CW'(1);
        end
      end
      if (s1_rdy) v1 <= accept;
      if (s2_rdy) v2 <= m1;
      if (s3_rdy) v3 <= m2;
      if (s4_rdy) v4 <= m3 && prod3;  // border pixels drop out here
      if (o_rdy)  vo <= m4;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      px1   <= pixel_in;
      col1  <= column_position;
      prod1 <= produce;
      last1 <= frame_end;
    end
    if (m1) begin
      px2   <= px1;
      col2  <= col1;
      prod2 <= prod1;
      last2 <= last1;
    end
    if (m2) begin
      prod3 <= prod2;
      last3 <= last2;
      for (int r = 0; r < KSIZE; r++) begin
        for (int c = 0; c < KSIZE - 1; c++) begin
          window[r*KSIZE+c] <= window[r*KSIZE+c+1];
        end
      end
      window[KSIZE-1]         <= upper_rd;
      window[2*KSIZE-1]       <= lower_rd;
      window[KSIZE*KSIZE-1]   <= px2;
    end
    if (m3) begin
      last4 <= last3;
    end
    if (m4) begin
      frame_last <= last4;
    end
  end

  assign out_valid = vo;

  cwf_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW   (CW)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (m1),
    .rd_addr (col1),
    .wr_en   (m2),
    .wr_addr (col2),
    .wr_pixel(px2),
    .upper_rd(upper_rd),
    .lower_rd(lower_rd)
  );

  assign mac_ctl.load_prod = m3;
  assign mac_ctl.load_sum  = m4;

  cwf_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .win      (window),
    .coef     (coef),
    .pixel_out(pixel_out)
  );

  // end of frame wraps both counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> (column_position == '0 && row_position == '0))
    else $error("counters did not wrap at frame end");

  // end of row steps the row counter
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (accept && row_end && !frame_end) |=>
      (column_position == '0 && row_position == $past(row_position) + FH_BITS'(1)))
    else $error("row counter did not advance at row end");

  // input is held off only when every stage up to the output is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && vo && out_stall))
    else $error("input stalled with room in the pipeline");

  // border pixels never reach the product stage
  a_border_drop: assert property (@(posedge clk) disable iff (rst)
    (m3 && !prod3) |=> !v4)
    else $error("border pixel produced a result");

endmodule

@@ src/cwf_line_store.sv @@
// Two line stores with per-entry valid bits and registered reads.
`timescale 1ns / 1ps

module cwf_line_store import cwf_pkg::*; #(
  parameter int DEPTH = CWF_MAX_WIDTH,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pixel_t        wr_pixel,
  output pixel_t        upper_rd,
  output pixel_t        lower_rd
);

  pixel_t           upper_mem [DEPTH];
  pixel_t           lower_mem [DEPTH];
  logic [DEPTH-1:0] upper_vld;
  logic [DEPTH-1:0] lower_vld;
  pixel_t           upper_q;
  pixel_t           lower_q;
  logic             upper_q_vld;
  logic             lower_q_vld;

  // never-written entries read as zero
  assign upper_rd = upper_q_vld ? upper_q : '0;
  assign lower_rd = lower_q_vld ? lower_q : '0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q     <= upper_mem[rd_addr];
      lower_q     <= lower_mem[rd_addr];
      upper_q_vld <= upper_vld[rd_addr];
      lower_q_vld <= lower_vld[rd_addr];
    end
    if (wr_en) begin
      upper_mem[wr_addr] <= lower_rd;  // lower row moves up
      lower_mem[wr_addr] <= wr_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_vld <= '0;
      lower_vld <= '0;
    end else if (wr_en) begin
      upper_vld[wr_addr] <= 1'b1;
      lower_vld[wr_addr] <= 1'b1;
    end
  end

endmodule

@@ src/cwf_mac.sv @@
// Nine-tap multiply and modulo-256 sum, two register stages.
`timescale 1ns / 1ps

module cwf_mac import cwf_pkg::*; (
  input  logic                          clk,
  input  cwf_mac_ctl_t                  ctl,
  input  logic [NTAPS-1:0][PIX_BITS-1:0] win,
  input  logic [KSIZE-1:0][COEF_BITS-1:0] coef,
  output pixel_t                        pixel_out
);

  logic [NTAPS-1:0][PIX_BITS-1:0] prod;
  logic [NTAPS-1:0][PIX_BITS-1:0] prod_next;
  pixel_t                         sum_next;

  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE; c++) begin
        prod_next[r*KSIZE+c] = prod_lo(win[r*KSIZE+c],
                                       coef[r][c*PIX_BITS +: PIX_BITS]);
      end
    end
  end

  // only the low byte survives, so an 8-bit accumulator is exact
  always_comb begin
    sum_next = '0;
    for (int k = 0; k < NTAPS; k++) begin
      sum_next = sum_next + prod[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod <= prod_next;
    end
    if (ctl.load_sum) begin
      pixel_out <= sum_next;
    end
  end

endmodule
